// ----- hw/rtl/bale_pkg.sv -----
`default_nettype none
package bale_pkg;

    // List geometry
    localparam int CAPACITY = 8;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int WORD_W   = 32;
    localparam int POS_W    = 8;
    localparam int OP_W     = 4;
    localparam int STAT_W   = 2;
    localparam int CNTF_W   = 4;

    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [POS_W-1:0]         pos_t;
    typedef logic [OP_W-1:0]          op_t;
    typedef logic [STAT_W-1:0]        stat_t;

    // Operation codes
    localparam op_t OP_INS_FRONT = 4'd0;
    localparam op_t OP_INS_BACK  = 4'd1;
    localparam op_t OP_RM_FRONT  = 4'd2;
    localparam op_t OP_RM_BACK   = 4'd3;
    localparam op_t OP_DEDUP     = 4'd4;
    localparam op_t OP_READ_POS  = 4'd5;
    localparam op_t OP_FIRST     = 4'd6;
    localparam op_t OP_LAST      = 4'd7;
    localparam op_t OP_SUCC      = 4'd8;
    localparam op_t OP_PRED      = 4'd9;

    // Status codes
    localparam stat_t ST_OK    = 2'd0;
    localparam stat_t ST_FULL  = 2'd1;
    localparam stat_t ST_EMPTY = 2'd2;
    localparam stat_t ST_RANGE = 2'd3;

    localparam word_t NO_DATA = '1;

    // Finished result handed from the sequencer to the output stage
    typedef struct packed {
        word_t data;
        stat_t status;
        cnt_t  count;
    } res_t;

endpackage
`default_nettype wire

// ----- hw/rtl/bale_store.sv -----
`default_nettype none
module bale_store (
    input  wire logic           clk,
    input  wire logic           wr_en,
    input  wire bale_pkg::idx_t wr_addr,
    input  wire bale_pkg::word_t wr_data,
    input  wire bale_pkg::idx_t rd_addr,
    output bale_pkg::word_t     rd_data
);
    import bale_pkg::*;

    word_t mem [CAPACITY];
    word_t rd_data_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/bale_seq.sv -----
`default_nettype none
module bale_seq (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire bale_pkg::op_t    operation,
    input  wire bale_pkg::word_t  value,
    input  wire bale_pkg::pos_t   position,
    output logic                  res_valid,
    output bale_pkg::res_t        res,
    input  wire logic             res_take
);
    import bale_pkg::*;

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] S_IDLE    = 4'd0;
    localparam logic [ST_W-1:0] S_UP_RD   = 4'd1;
    localparam logic [ST_W-1:0] S_UP_WR   = 4'd2;
    localparam logic [ST_W-1:0] S_PUT     = 4'd3;
    localparam logic [ST_W-1:0] S_DN_RD   = 4'd4;
    localparam logic [ST_W-1:0] S_DN_WR   = 4'd5;
    localparam logic [ST_W-1:0] S_RD_WAIT = 4'd6;
    localparam logic [ST_W-1:0] S_DD_GET  = 4'd7;
    localparam logic [ST_W-1:0] S_DD_CMP  = 4'd8;
    localparam logic [ST_W-1:0] S_DONE    = 4'd9;

    logic [ST_W-1:0] state_reg, state_next;
    cnt_t  count_reg, count_next;
    cnt_t  k_reg, k_next;        // shift index, or scan index in dedup
    cnt_t  w_reg, w_next;        // kept entries in dedup
    cnt_t  m_reg, m_next;        // compare index in dedup
    word_t cand_reg, cand_next;
    word_t val_reg, val_next;
    word_t data_reg, data_next;
    stat_t stat_reg, stat_next;

    logic  wr_en;
    idx_t  wr_addr;
    word_t wr_data;
    idx_t  rd_addr;
    word_t rd_data;

    bale_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Widened operands for the range checks
    logic [POS_W:0] pos_x, cnt_x, pos_inc;
    logic [CNT_W:0] k_inc, k_inc2, m_inc, cnt_w;
    logic           same;
    logic           keep, adv;
    word_t          keep_val;

    assign pos_x   = {1'b0, position};
    assign cnt_x   = (POS_W + 1)'(count_reg);
    assign pos_inc = pos_x + 1'b1;
    assign cnt_w   = {1'b0, count_reg};
    assign k_inc   = {1'b0, k_reg} + 1'b1;
    assign k_inc2  = {1'b0, k_reg} + 2'd2;
    assign m_inc   = {1'b0, m_reg} + 1'b1;

    // The dedup value comparator
    assign same = (rd_data == cand_reg);

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = '{data: data_reg, status: stat_reg, count: count_reg};

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        k_next     = k_reg;
        w_next     = w_reg;
        m_next     = m_reg;
        cand_next  = cand_reg;
        val_next   = val_reg;
        data_next  = data_reg;
        stat_next  = stat_reg;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = value;
        rd_addr    = '0;
        keep       = 1'b0;
        adv        = 1'b0;
        keep_val   = cand_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    data_next  = NO_DATA;
                    stat_next  = ST_OK;
                    val_next   = value;
                    state_next = S_DONE;
                    unique case (operation)
                        OP_INS_FRONT:
                        begin
                            if (cnt_w >= (CNT_W + 1)'(CAPACITY))
                            begin
                                stat_next = ST_FULL;
                            end
                            else if (count_reg == '0)
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = '0;
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                k_next     = count_reg;
                                state_next = S_UP_RD;
                            end
                        end
                        OP_INS_BACK:
                        begin
                            if (cnt_w >= (CNT_W + 1)'(CAPACITY))
                            begin
                                stat_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = count_reg[IDX_W-1:0];
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_RM_FRONT:
                        begin
                            if (count_reg == '0)
                            begin
                                stat_next = ST_EMPTY;
                            end
                            else if (count_reg == cnt_t'(1))
                            begin
                                count_next = '0;
                            end
                            else
                            begin
                                k_next     = '0;
                                state_next = S_DN_RD;
                            end
                        end
                        OP_RM_BACK:
                        begin
                            if (count_reg == '0)
                                stat_next = ST_EMPTY;
                            else
                                count_next = count_reg - 1'b1;
                        end
                        OP_DEDUP:
                        begin
                            if (count_reg != '0)
                            begin
                                rd_addr    = '0;
                                k_next     = '0;
                                w_next     = '0;
                                state_next = S_DD_GET;
                            end
                        end
                        OP_READ_POS:
                        begin
                            if (pos_x < cnt_x)
                            begin
                                rd_addr    = position[IDX_W-1:0];
                                state_next = S_RD_WAIT;
                            end
                            else
                            begin
                                stat_next = ST_RANGE;
                            end
                        end
                        OP_FIRST:
                        begin
                            if (count_reg == '0)
                            begin
                                stat_next = ST_EMPTY;
                            end
                            else
                            begin
                                rd_addr    = '0;
                                state_next = S_RD_WAIT;
                            end
                        end
                        OP_LAST:
                        begin
                            if (count_reg == '0)
                            begin
                                stat_next = ST_EMPTY;
                            end
                            else
                            begin
                                rd_addr    = idx_t'(count_reg - 1'b1);
                                state_next = S_RD_WAIT;
                            end
                        end
                        OP_SUCC:
                        begin
                            if (pos_inc < cnt_x)
                            begin
                                rd_addr    = pos_inc[IDX_W-1:0];
                                state_next = S_RD_WAIT;
                            end
                            else
                            begin
                                stat_next = ST_RANGE;
                            end
                        end
                        OP_PRED:
                        begin
                            if (position != '0 && pos_x < cnt_x)
                            begin
                                rd_addr    = idx_t'(position - 1'b1);
                                state_next = S_RD_WAIT;
                            end
                            else
                            begin
                                stat_next = ST_RANGE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // Insert at front: move entries up, top first
            S_UP_RD:
            begin
                rd_addr    = idx_t'(k_reg - 1'b1);
                state_next = S_UP_WR;
            end
            S_UP_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = k_reg[IDX_W-1:0];
                wr_data = rd_data;
                if (k_reg == cnt_t'(1))
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    k_next     = k_reg - 1'b1;
                    state_next = S_UP_RD;
                end
            end
            S_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = val_reg;
                count_next = count_reg + 1'b1;
                state_next = S_DONE;
            end

            // Remove at front: move entries down, bottom first
            S_DN_RD:
            begin
                rd_addr    = k_inc[IDX_W-1:0];
                state_next = S_DN_WR;
            end
            S_DN_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = k_reg[IDX_W-1:0];
                wr_data = rd_data;
                k_next  = k_reg + 1'b1;
                if (k_inc2 < cnt_w)
                begin
                    state_next = S_DN_RD;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_DONE;
                end
            end

            S_RD_WAIT:
            begin
                data_next  = rd_data;
                state_next = S_DONE;
            end

            // Dedup: compact in place, each candidate checked against kept ones
            S_DD_GET:
            begin
                cand_next = rd_data;
                if (w_reg == '0)
                begin
                    keep     = 1'b1;
                    keep_val = rd_data;
                end
                else
                begin
                    rd_addr    = '0;
                    m_next     = '0;
                    state_next = S_DD_CMP;
                end
            end
            S_DD_CMP:
            begin
                if (same)
                begin
                    adv = 1'b1;
                end
                else if (m_inc == {1'b0, w_reg})
                begin
                    keep = 1'b1;
                end
                else
                begin
                    m_next  = m_reg + 1'b1;
                    rd_addr = m_inc[IDX_W-1:0];
                end
            end

            S_DONE:
            begin
                if (res_take)
                    state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Dedup bookkeeping: store a kept value, then step to the next entry
        if (keep)
        begin
            wr_en   = 1'b1;
            wr_addr = w_reg[IDX_W-1:0];
            wr_data = keep_val;
            w_next  = w_reg + 1'b1;
            adv     = 1'b1;
        end
        if (adv)
        begin
            if (k_inc == cnt_w)
            begin
                count_next = w_next;
                state_next = S_DONE;
            end
            else
            begin
                k_next     = k_reg + 1'b1;
                rd_addr    = k_inc[IDX_W-1:0];
                state_next = S_DD_GET;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        w_reg    <= w_next;
        m_reg    <= m_next;
        cand_reg <= cand_next;
        val_reg  <= val_next;
        data_reg <= data_next;
        stat_reg <= stat_next;
    end

endmodule
`default_nettype wire

// ----- hw/rtl/bounded_array_list_engine.sv -----
`default_nettype none
// Channel  Dir  Fields (low bit first)
// s_axis   in   tuser: operation[3:0]; tdata: value[31:0], position[39:32]
// m_axis   out  tdata: data[31:0], status[33:32], count[37:34],
//               is_empty[38], is_full[39]
//
// One request at a time through a sequencer around a list store with one write and one read port.
// Back insert/remove and refusals go straight to the result; reads first wait for
// the registered store read. Front insert moves the entries up one by one, then
// writes the new value; front remove moves them down. Dedup compares one pair at a time.
// Reset clears the count; list contents need no clearing.
// A finished result sits in the output register while the next request enters.
module bounded_array_list_engine (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // value, position
    input  wire logic [3:0]  s_axis_tuser,   // operation
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata    // data, status, count, is_empty, is_full
);
    import bale_pkg::*;

    logic res_valid;
    res_t res;
    logic res_take;

    logic out_valid_reg, out_valid_next;
    res_t out_res_reg;

    bale_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .operation (s_axis_tuser),
        .value     (s_axis_tdata[31:0]),
        .position  (s_axis_tdata[39:32]),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take)
    );

    // Output register: loads when empty or being drained
    assign res_take = res_valid && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
            out_res_reg <= res;
    end

    // Pack the result transfer
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {
        (out_res_reg.count == cnt_t'(CAPACITY)),
        (out_res_reg.count == '0),
        CNTF_W'(out_res_reg.count),
        out_res_reg.status,
        out_res_reg.data
    };

endmodule
`default_nettype wire
